// ===== src/ems_pkg.sv =====
package ems_pkg;

  // field and register widths
  localparam int TS_W       = 32;
  localparam int COUNT_W    = 32;
  localparam int PERIOD_W   = 20;
  localparam int RES_W      = 24;
  localparam int CFG_DATA_W = 24;
  localparam int CFG_IDX_W  = 1;
  localparam int SPEED_W    = 24;

  // speed datapath: |d| * res * 15625 / (dt * 1024)
  localparam int PROD_W   = COUNT_W + RES_W;
  localparam int SCALE_W  = 14;
  localparam int SPLIT    = PROD_W / 2;
  localparam int PART_W   = (PROD_W - SPLIT) + SCALE_W;
  localparam int FULL_W   = PROD_W + SCALE_W;
  localparam int DT_SHIFT = 10;

  // speed serial divider
  localparam int NUM_W  = FULL_W - DT_SHIFT;
  localparam int DEN_W  = TS_W;
  localparam int Q_W    = SPEED_W + 1;
  localparam int HI_W   = NUM_W - Q_W;
  localparam int STEP_W = $clog2(Q_W + 1);

  localparam logic [SCALE_W-1:0] SPEED_SCALE = 14'd15625;
  localparam logic [Q_W-1:0]     SPD_LIM_POS = 25'd8388607;
  localparam logic [Q_W-1:0]     SPD_LIM_NEG = 25'd8388608;

  localparam logic [PERIOD_W-1:0] PERIOD_RST = 20'd5000;
  localparam logic [RES_W-1:0]    RES_RST    = 24'd95630;

  localparam int WINDOW_LEN_DEF = 200;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_PERIOD = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RESOLUTION    = 1'd1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL,
    ST_PART,
    ST_SDIV,
    ST_SWAIT,
    ST_UPD,
    ST_MDIV,
    ST_MWAIT,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic load;
    logic mul;
    logic part;
    logic start_spd;
    logic fin_spd;
    logic upd;
    logic start_mean;
    logic fin_mean;
  } lane_ctl_t;

endpackage

// ===== src/encoder_speed_moving_average.sv =====
// two-wheel encoder speed estimator with a sliding-window mean
//
// input channel (in_valid / in_stall): one transfer carries a microsecond
// timestamp and the left and right encoder counts. a transfer arriving less
// than sample_period_us after the last used sample is dropped. otherwise
// each wheel gets an instantaneous speed in 2^-8 rad/s, clipped to 24
// bits, which enters a WINDOW_LEN-deep ring in block ram.
// result channel (out_valid / out_stall): one transfer per used sample with
// the floor mean of the window per wheel and a clip flag.
// a new item is taken only once the result is in the output register.
// each wheel lane divides by the elapsed time in a 25-step serial divider;
// the mean by WINDOW_LEN is a reciprocal multiply with registered partials.
// a stalled result sits in the output register while the next item is
// already being worked on; that item then waits for the register to empty.
// reset (synchronous, rst_n low) clears the sums, last sample and ring
// pointer and restores the register defaults; ring entries not yet written
// since reset read as zero, so no clearing pass is needed.
// cfg_we writes cfg_data to the register chosen by cfg_index; the user
// must do so only when idle, as the block itself does not enforce it.
module encoder_speed_moving_average #(
  parameter int WINDOW_LEN = ems_pkg::WINDOW_LEN_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // configuration
  input  logic                                cfg_we,
  input  logic [ems_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [ems_pkg::CFG_DATA_W-1:0]      cfg_data,
  // input channel
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [ems_pkg::TS_W-1:0]            in_timestamp_us,
  input  logic signed [ems_pkg::COUNT_W-1:0]  in_count_left,
  input  logic signed [ems_pkg::COUNT_W-1:0]  in_count_right,
  // result channel
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [ems_pkg::SPEED_W-1:0]  out_speed_left,
  output logic signed [ems_pkg::SPEED_W-1:0]  out_speed_right,
  output logic                                out_saturated
);
  import ems_pkg::*;

  localparam int PTR_W = $clog2(WINDOW_LEN);
  localparam int ENT_W = 2 * SPEED_W;

  // configuration registers
  logic [PERIOD_W-1:0] period_r;
  logic [RES_W-1:0]    res_r;

  // sequencer and shared scalar state
  state_t           state_r, state_nxt;
  logic [TS_W-1:0]  last_time_r;
  logic [DEN_W-1:0] dt_r;
  logic [PTR_W-1:0] ptr_r, ptr_nxt;
  logic             wrapped_r, wrapped_nxt;

  // output register
  logic                      out_valid_r, out_valid_nxt;
  logic signed [SPEED_W-1:0] out_left_r, out_right_r;
  logic                      out_sat_r;

  lane_ctl_t ctl;
  logic      in_xfer;
  logic      out_load;
  logic      use_sample;

  logic [TS_W-1:0]     dt;
  logic [PERIOD_W-1:0] period_eff;

  logic [ENT_W-1:0]          ram_rdata;
  logic signed [SPEED_W-1:0] old_left, old_right;
  logic signed [SPEED_W-1:0] speed_left, speed_right;
  logic signed [SPEED_W-1:0] mean_left, mean_right;
  logic                      sat_left, sat_right;
  logic                      done_left, done_right;

  assign in_xfer    = in_valid && !in_stall;
  assign period_eff = (period_r == '0) ? PERIOD_W'(1) : period_r;
  assign dt         = in_timestamp_us - last_time_r;
  // elapsed time wraps modulo 2^32
  assign use_sample = dt >= TS_W'(period_eff);

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      period_r <= PERIOD_RST;
      res_r    <= RES_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_SAMPLE_PERIOD: period_r <= cfg_data[PERIOD_W-1:0];
        CFG_RESOLUTION:    res_r    <= cfg_data[RES_W-1:0];
        default: ;
      endcase
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:  if (in_xfer && use_sample) state_nxt = ST_MUL;
      ST_MUL:   state_nxt = ST_PART;
      ST_PART:  state_nxt = ST_SDIV;
      ST_SDIV:  state_nxt = ST_SWAIT;
      ST_SWAIT: if (done_left && done_right) state_nxt = ST_UPD;
      ST_UPD:   state_nxt = ST_MDIV;
      ST_MDIV:  state_nxt = ST_MWAIT;
      ST_MWAIT: state_nxt = ST_OUT;
      ST_OUT:   if (out_load) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    ctl      = '0;
    in_stall = 1'b1;
    out_load = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        ctl.load = in_valid && use_sample;
      end
      ST_MUL:   ctl.mul = 1'b1;
      ST_PART:  ctl.part = 1'b1;
      ST_SDIV:  ctl.start_spd = 1'b1;
      ST_SWAIT: ctl.fin_spd = done_left && done_right;
      ST_UPD:   ctl.upd = 1'b1;
      ST_MDIV:  ctl.start_mean = 1'b1;
      ST_MWAIT: ctl.fin_mean = 1'b1;
      ST_OUT:   out_load = !out_valid_r || !out_stall;
      default: ;
    endcase
  end

  // ring pointer; wrapped marks that every entry has been written once
  always_comb begin
    ptr_nxt     = ptr_r;
    wrapped_nxt = wrapped_r;
    if (ctl.upd) begin
      if (ptr_r == PTR_W'(WINDOW_LEN - 1)) begin
        ptr_nxt     = '0;
        wrapped_nxt = 1'b1;
      end else begin
        ptr_nxt = ptr_r + PTR_W'(1);
      end
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      last_time_r <= '0;
      ptr_r       <= '0;
      wrapped_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ptr_r       <= ptr_nxt;
      wrapped_r   <= wrapped_nxt;
      out_valid_r <= out_valid_nxt;
      if (ctl.load) begin
        last_time_r <= in_timestamp_us;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      dt_r <= dt;
    end
    if (out_load) begin
      out_left_r  <= mean_left;
      out_right_r <= mean_right;
      out_sat_r   <= sat_left | sat_right;
    end
  end

  // window ring: left speed in the upper half, right in the lower
  // read address stays on the current slot, so the oldest value is ready
  ems_ram #(
    .WIDTH (ENT_W),
    .DEPTH (WINDOW_LEN)
  ) u_ring (
    .clk   (clk),
    .we    (ctl.upd),
    .waddr (ptr_r),
    .wdata ({speed_left, speed_right}),
    .raddr (ptr_r),
    .rdata (ram_rdata)
  );

  // slots not written since reset hold zero
  assign old_left  = wrapped_r ? $signed(ram_rdata[ENT_W-1:SPEED_W]) : '0;
  assign old_right = wrapped_r ? $signed(ram_rdata[SPEED_W-1:0]) : '0;

  ems_lane #(
    .WINDOW_LEN (WINDOW_LEN)
  ) u_lane_left (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (ctl),
    .count     (in_count_left),
    .res       (res_r),
    .dt        (dt_r),
    .old_speed (old_left),
    .speed     (speed_left),
    .sat       (sat_left),
    .mean      (mean_left),
    .div_done  (done_left)
  );

  ems_lane #(
    .WINDOW_LEN (WINDOW_LEN)
  ) u_lane_right (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (ctl),
    .count     (in_count_right),
    .res       (res_r),
    .dt        (dt_r),
    .old_speed (old_right),
    .speed     (speed_right),
    .sat       (sat_right),
    .mean      (mean_right),
    .div_done  (done_right)
  );

  assign out_valid       = out_valid_r;
  assign out_speed_left  = out_left_r;
  assign out_speed_right = out_right_r;
  assign out_saturated   = out_sat_r;

endmodule

// ===== src/ems_ram.sv =====
module ems_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 200
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== src/ems_div.sv =====
module ems_div (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [ems_pkg::NUM_W-1:0] num,
  input  logic [ems_pkg::DEN_W-1:0] den,
  output logic                      done,
  output logic [ems_pkg::Q_W-1:0]   quot,
  output logic                      ovf
);
  import ems_pkg::*;

  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [STEP_W-1:0] cnt_r, cnt_nxt;
  logic [DEN_W-1:0]  rem_r, rem_nxt;
  logic [DEN_W-1:0]  den_r, den_nxt;
  logic [Q_W-1:0]    sh_r, sh_nxt;
  logic              ovf_r, ovf_nxt;

  logic [HI_W-1:0]  hi;
  logic [DEN_W:0]   trial;
  logic             ge;

  assign hi    = num[NUM_W-1:Q_W];
  assign trial = {rem_r, sh_r[Q_W-1]};
  assign ge    = trial >= {1'b0, den_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    sh_nxt   = sh_r;
    ovf_nxt  = ovf_r;
    if (start) begin
      // quotient beyond Q_W bits shows up as the top part not below the divisor
      busy_nxt = 1'b1;
      cnt_nxt  = STEP_W'(Q_W);
      rem_nxt  = hi[DEN_W-1:0];
      den_nxt  = den;
      sh_nxt   = num[Q_W-1:0];
      ovf_nxt  = hi >= HI_W'(den);
    end else if (busy_r) begin
      rem_nxt = ge ? DEN_W'(trial - {1'b0, den_r}) : trial[DEN_W-1:0];
      sh_nxt  = {sh_r[Q_W-2:0], ge};
      cnt_nxt = cnt_r - STEP_W'(1);
      if (cnt_r == STEP_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    den_r <= den_nxt;
    sh_r  <= sh_nxt;
    ovf_r <= ovf_nxt;
  end

  assign done = done_r;
  assign quot = sh_r;
  assign ovf  = ovf_r;

endmodule

// ===== src/ems_lane.sv =====
module ems_lane #(
  parameter int WINDOW_LEN = ems_pkg::WINDOW_LEN_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  ems_pkg::lane_ctl_t                 ctl,
  input  logic signed [ems_pkg::COUNT_W-1:0] count,
  input  logic [ems_pkg::RES_W-1:0]          res,
  input  logic [ems_pkg::DEN_W-1:0]          dt,
  input  logic signed [ems_pkg::SPEED_W-1:0] old_speed,
  output logic signed [ems_pkg::SPEED_W-1:0] speed,
  output logic                               sat,
  output logic signed [ems_pkg::SPEED_W-1:0] mean,
  output logic                               div_done
);
  import ems_pkg::*;

  localparam int SUM_W = SPEED_W + $clog2(WINDOW_LEN);
  localparam logic [SUM_W:0]   MEAN_BIAS = (SUM_W + 1)'(WINDOW_LEN) << (SPEED_W - 1);

  // floor(x / WINDOW_LEN) as (x * RECIP) >> RSH, exact for every MU_W-bit x
  localparam int MU_W  = SUM_W + 1;
  localparam int RSH   = MU_W + $clog2(WINDOW_LEN);
  localparam int RCP_W = MU_W + 1;
  localparam int LO_W  = (RCP_W + 1) / 2;
  localparam int PP_W  = 2 * LO_W;
  localparam int MP_W  = MU_W + RCP_W;
  localparam logic [RCP_W-1:0] RECIP =
    RCP_W'(((64'd1 << RSH) + 64'(WINDOW_LEN) - 64'd1) / 64'(WINDOW_LEN));

  logic [COUNT_W-1:0]        last_r;
  logic signed [SUM_W-1:0]   sum_r, sum_nxt;
  logic                      neg_r;
  logic [COUNT_W-1:0]        mag_r;
  logic [PROD_W-1:0]         prod_r;
  logic [PART_W-1:0]         plo_r, phi_r;
  logic signed [SPEED_W-1:0] speed_r;
  logic                      sat_r;
  logic [PP_W-1:0]           pll_r, plh_r, phl_r, phh_r;
  logic signed [SPEED_W-1:0] mean_r;

  logic [COUNT_W-1:0] delta;
  logic [FULL_W-1:0]  full;
  logic [SUM_W:0]     mean_u;
  logic [MP_W-1:0]    mprod;
  logic               dv_start;
  logic [NUM_W-1:0]   dv_num;
  logic [DEN_W-1:0]   dv_den;
  logic [Q_W-1:0]     dv_quot;
  logic               dv_ovf;
  logic [Q_W-1:0]     lim;
  logic               clip;
  logic [SPEED_W-1:0] mag_sat;

  assign delta = count - last_r;

  // recombine the two partial products, drop the 1024 of the divisor
  assign full = FULL_W'(plo_r) + (FULL_W'(phi_r) << SPLIT);

  // bias makes the sum non-negative so a plain quotient gives the floor mean
  assign mean_u = $unsigned({sum_r[SUM_W-1], sum_r}) + MEAN_BIAS;

  // reciprocal product from the four registered partial products
  assign mprod = MP_W'(pll_r) + (MP_W'(plh_r) << LO_W) + (MP_W'(phl_r) << LO_W)
               + (MP_W'(phh_r) << PP_W);

  assign dv_start = ctl.start_spd;
  assign dv_num   = full[FULL_W-1:DT_SHIFT];
  assign dv_den   = dt;

  ems_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (dv_start),
    .num   (dv_num),
    .den   (dv_den),
    .done  (div_done),
    .quot  (dv_quot),
    .ovf   (dv_ovf)
  );

  assign lim     = neg_r ? SPD_LIM_NEG : SPD_LIM_POS;
  assign clip    = dv_ovf || (dv_quot > lim);
  assign mag_sat = clip ? lim[SPEED_W-1:0] : dv_quot[SPEED_W-1:0];

  always_comb begin
    sum_nxt = sum_r;
    if (ctl.upd) begin
      sum_nxt = sum_r + SUM_W'(speed_r) - SUM_W'(old_speed);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_r <= '0;
      sum_r  <= '0;
    end else begin
      sum_r <= sum_nxt;
      if (ctl.load) begin
        last_r <= count;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      neg_r <= delta[COUNT_W-1];
      mag_r <= delta[COUNT_W-1] ? (~delta + COUNT_W'(1)) : delta;
    end
    if (ctl.mul) begin
      prod_r <= PROD_W'(mag_r) * PROD_W'(res);
    end
    if (ctl.part) begin
      plo_r <= PART_W'(prod_r[SPLIT-1:0]) * PART_W'(SPEED_SCALE);
      phi_r <= PART_W'(prod_r[PROD_W-1:SPLIT]) * PART_W'(SPEED_SCALE);
    end
    if (ctl.fin_spd) begin
      speed_r <= neg_r ? -$signed(mag_sat) : $signed(mag_sat);
      sat_r   <= clip;
    end
    if (ctl.start_mean) begin
      pll_r <= PP_W'(mean_u[LO_W-1:0]) * PP_W'(RECIP[LO_W-1:0]);
      plh_r <= PP_W'(mean_u[LO_W-1:0]) * PP_W'(RECIP[RCP_W-1:LO_W]);
      phl_r <= PP_W'(mean_u[SUM_W:LO_W]) * PP_W'(RECIP[LO_W-1:0]);
      phh_r <= PP_W'(mean_u[SUM_W:LO_W]) * PP_W'(RECIP[RCP_W-1:LO_W]);
    end
    if (ctl.fin_mean) begin
      // remove the bias again: flip the top bit of the quotient
      mean_r <= $signed({~mprod[RSH+SPEED_W-1], mprod[RSH+SPEED_W-2:RSH]});
    end
  end

  assign speed = speed_r;
  assign sat   = sat_r;
  assign mean  = mean_r;

endmodule

// ===== test/ems_speed_checker.sv =====
module ems_speed_checker
  import ems_pkg::*;
#(
  parameter int WINDOW_LEN = WINDOW_LEN_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_valid,
  input  logic                  in_stall,
  input  logic [TS_W-1:0]       in_timestamp_us,
  input  logic [COUNT_W-1:0]    in_count_left,
  input  logic [COUNT_W-1:0]    in_count_right,
  input  logic                  out_valid,
  input  logic                  out_stall,
  input  logic [SPEED_W-1:0]    out_speed_left,
  input  logic [SPEED_W-1:0]    out_speed_right,
  input  logic                  out_saturated,
  output int                    mismatches,
  output int                    pending
);

  typedef struct packed {
    logic [SPEED_W-1:0] left;
    logic [SPEED_W-1:0] right;
    logic               sat;
  } speed_pair_t;

  logic [PERIOD_W-1:0] period_q;
  logic [RES_W-1:0]    res_q;
  logic [TS_W-1:0]     last_time;
  logic [COUNT_W-1:0]  last_left;
  logic [COUNT_W-1:0]  last_right;
  int                  win_left[WINDOW_LEN];
  int                  win_right[WINDOW_LEN];
  longint              sum_left;
  longint              sum_right;
  int                  ring_ptr;
  speed_pair_t         expected_speeds[$];
  int                  fails = 0;

  // |d| * res * 10^6 / (dt * 2^16), split so the scale multiply cannot overflow
  function automatic logic [SPEED_W-1:0] wheel_speed(input logic [COUNT_W-1:0] cnt,
                                                     input logic [COUNT_W-1:0] prev,
                                                     input logic [TS_W-1:0] dt,
                                                     inout logic clipped);
    logic [COUNT_W-1:0] d;
    logic [COUNT_W-1:0] mag32;
    logic               neg;
    longint unsigned    mag, prod, den, lim, qa, ra, q;
    logic [63:0]        val;
    d     = cnt - prev;
    neg   = d[COUNT_W-1];
    mag32 = neg ? -d : d;
    mag   = mag32;
    prod  = mag * res_q;
    den   = dt;
    den   = den << DT_SHIFT;
    lim   = neg ? SPD_LIM_NEG : SPD_LIM_POS;
    qa    = prod / den;
    ra    = prod % den;
    if (qa > lim) begin
      clipped = 1'b1;
      q = lim;
    end else begin
      q = qa * SPEED_SCALE + (ra * SPEED_SCALE) / den;
      if (q > lim) begin
        clipped = 1'b1;
        q = lim;
      end
    end
    val = neg ? -q : q;
    return val[SPEED_W-1:0];
  endfunction

  // floor division, rounding towards minus infinity
  function automatic logic [SPEED_W-1:0] window_mean(input longint total);
    longint q;
    q = total / WINDOW_LEN;
    if (total < 0 && q * WINDOW_LEN != total) q = q - 1;
    return q[SPEED_W-1:0];
  endfunction

  always @(posedge clk) begin : watch
    logic [TS_W-1:0]    dt;
    logic [TS_W-1:0]    eff;
    logic [SPEED_W-1:0] vl, vr;
    logic               clip;
    int                 nl, nr;
    speed_pair_t        exp_r;
    if (!rst_n) begin
      period_q   = PERIOD_RST;
      res_q      = RES_RST;
      last_time  = '0;
      last_left  = '0;
      last_right = '0;
      for (int i = 0; i < WINDOW_LEN; i++) begin
        win_left[i]  = 0;
        win_right[i] = 0;
      end
      sum_left  = 0;
      sum_right = 0;
      ring_ptr  = 0;
      expected_speeds.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_SAMPLE_PERIOD: period_q = cfg_data[PERIOD_W-1:0];
          CFG_RESOLUTION:    res_q    = cfg_data[RES_W-1:0];
          default: ;
        endcase
      end

      if (in_valid && !in_stall) begin
        eff = (period_q == '0) ? 1 : period_q;
        dt  = in_timestamp_us - last_time;
        if (dt >= eff) begin
          clip = 1'b0;
          vl   = wheel_speed(in_count_left, last_left, dt, clip);
          vr   = wheel_speed(in_count_right, last_right, dt, clip);
          nl   = signed'(vl);
          nr   = signed'(vr);
          sum_left  = sum_left + nl - win_left[ring_ptr];
          sum_right = sum_right + nr - win_right[ring_ptr];
          win_left[ring_ptr]  = nl;
          win_right[ring_ptr] = nr;
          ring_ptr   = (ring_ptr + 1) % WINDOW_LEN;
          last_time  = in_timestamp_us;
          last_left  = in_count_left;
          last_right = in_count_right;
          expected_speeds.push_back({window_mean(sum_left), window_mean(sum_right), clip});
        end
      end

      if (out_valid && !out_stall) begin
        if (expected_speeds.size() == 0) begin
          fails++;
          if (fails <= 10)
            $display("unexpected result transfer: left=%0d right=%0d sat=%0b",
                     $signed(out_speed_left), $signed(out_speed_right), out_saturated);
        end else begin
          exp_r = expected_speeds.pop_front();
          if (exp_r.left !== out_speed_left || exp_r.right !== out_speed_right ||
              exp_r.sat !== out_saturated) begin
            fails++;
            if (fails <= 10)
              $display("speed mismatch: expected left=%0d right=%0d sat=%0b, got left=%0d right=%0d sat=%0b",
                       $signed(exp_r.left), $signed(exp_r.right), exp_r.sat,
                       $signed(out_speed_left), $signed(out_speed_right), out_saturated);
          end
        end
      end
    end
    mismatches = fails;
    pending    = expected_speeds.size();
  end

endmodule

// ===== test/tb.sv =====
module tb;
  import ems_pkg::*;

  // settle time after the last result, to cover any work still in flight
  localparam int SETTLE_CYCLES = 70;
  // long receiver hold-off, several samples' worth, to back the block up
  localparam int LONG_HOLD     = 400;

  logic                      clk = 1'b0;
  logic                      rst_n;
  logic                      cfg_we;
  logic [CFG_IDX_W-1:0]      cfg_index;
  logic [CFG_DATA_W-1:0]     cfg_data;
  logic                      in_valid;
  logic                      in_stall;
  logic [TS_W-1:0]           in_timestamp_us;
  logic signed [COUNT_W-1:0] in_count_left;
  logic signed [COUNT_W-1:0] in_count_right;
  logic                      out_valid;
  logic                      out_stall;
  logic signed [SPEED_W-1:0] out_speed_left;
  logic signed [SPEED_W-1:0] out_speed_right;
  logic                      out_saturated;

  int mismatches;
  int pending;

  // stimulus-side view of the sample gate, used only to shape timestamps
  logic [31:0] last_used;
  logic [31:0] eff_period;
  logic [31:0] prev_l;
  logic [31:0] prev_r;
  int          used_items;
  int          calm_items;
  bit          long_hold = 1'b0;

  always #1 clk = ~clk;

  encoder_speed_moving_average i_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_timestamp_us (in_timestamp_us),
    .in_count_left   (in_count_left),
    .in_count_right  (in_count_right),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_speed_left  (out_speed_left),
    .out_speed_right (out_speed_right),
    .out_saturated   (out_saturated)
  );

  ems_speed_checker i_check (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_timestamp_us (in_timestamp_us),
    .in_count_left   (in_count_left),
    .in_count_right  (in_count_right),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_speed_left  (out_speed_left),
    .out_speed_right (out_speed_right),
    .out_saturated   (out_saturated),
    .mismatches      (mismatches),
    .pending         (pending)
  );

  // mostly back-to-back, sometimes a short pause, rarely a long one
  function automatic int sender_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 80);
  endfunction

  // signed encoder step, magnitude class picked at random
  function automatic logic [31:0] walk_step();
    int unsigned lim;
    case ($urandom_range(0, 3))
      0:       lim = 100;
      1:       lim = 3000;
      2:       lim = 40000;
      default: lim = 1 << 24;
    endcase
    return $urandom_range(0, 2 * lim) - lim;
  endfunction

  // one input transfer; stall is looked at on the falling edge, where it is settled
  task automatic offer(input logic [31:0] ts, input logic [31:0] cl, input logic [31:0] cr);
    logic ok;
    int   gap;
    in_valid        <= 1'b1;
    in_timestamp_us <= ts;
    in_count_left   <= cl;
    in_count_right  <= cr;
    do begin
      @(negedge clk);
      ok = !in_stall;
      @(posedge clk);
    end while (!ok);
    if (ts - last_used >= eff_period) begin
      last_used = ts;
      used_items++;
    end
    prev_l = cl;
    prev_r = cr;
    if (calm_items > 0) begin
      calm_items--;
      gap = 0;
    end else begin
      gap = sender_gap();
    end
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // sender stops until every predicted result has come out
  task automatic drain();
    in_valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    @(posedge clk);
  endtask

  task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // registers only change once the block has gone quiet
  task automatic reconfigure(input logic [CFG_DATA_W-1:0] period, input logic [CFG_DATA_W-1:0] res);
    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    set_reg(CFG_SAMPLE_PERIOD, period);
    set_reg(CFG_RESOLUTION, res);
    eff_period = (period[PERIOD_W-1:0] == '0) ? 32'd1 : 32'(period[PERIOD_W-1:0]);
  endtask

  // random samples until enough of them have passed the period gate
  task automatic run_phase(input int target);
    int          first;
    int          r;
    logic [31:0] ts, cl, cr;
    first = used_items;
    while (used_items - first < target) begin
      if (calm_items == 0 && $urandom_range(0, 99) < 2) calm_items = $urandom_range(20, 60);
      r = $urandom_range(0, 99);
      if (r < 70) begin
        // well-formed sample: period elapsed, plausible wheel motion
        ts = last_used + eff_period;
        if (r >= 10) ts = ts + $urandom_range(0, eff_period);
        cl = prev_l + walk_step();
        cr = prev_r + walk_step();
      end else if (r < 82) begin
        // too early, must be dropped
        ts = last_used + $urandom_range(0, eff_period - 1);
        cl = prev_l + walk_step();
        cr = prev_r + walk_step();
      end else if (r < 92) begin
        // pure noise on every field
        ts = $urandom;
        cl = $urandom;
        cr = $urandom;
      end else begin
        // used sample with wild counts, mostly clipping
        ts = last_used + eff_period + $urandom_range(0, 3 * eff_period);
        cl = $urandom;
        cr = $urandom;
      end
      offer(ts, cl, cr);
    end
  endtask

  // receiver: random stalls, quiet stretches, and one long hold-off on request
  initial begin : receiver
    int   r;
    int   len;
    logic lvl;
    out_stall = 1'b0;
    @(posedge clk);
    forever begin
      if (long_hold) begin
        long_hold = 1'b0;
        lvl = 1'b1;
        len = LONG_HOLD;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 5) begin
          lvl = 1'b0;
          len = $urandom_range(100, 300);
        end else if (r < 60) begin
          lvl = 1'b0;
          len = $urandom_range(1, 4);
        end else if (r < 92) begin
          lvl = 1'b1;
          len = $urandom_range(1, 3);
        end else begin
          lvl = 1'b1;
          len = $urandom_range(10, 60);
        end
      end
      out_stall <= lvl;
      repeat (len) @(posedge clk);
    end
  end

  initial begin : stimulus
    rst_n           = 1'b0;
    cfg_we          = 1'b0;
    cfg_index       = CFG_SAMPLE_PERIOD;
    cfg_data        = '0;
    in_valid        = 1'b0;
    in_timestamp_us = '0;
    in_count_left   = '0;
    in_count_right  = '0;
    last_used       = '0;
    eff_period      = 32'(PERIOD_RST);
    prev_l          = '0;
    prev_r          = '0;
    used_items      = 0;
    calm_items      = 0;

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset defaults; the first sample is timed from zero against zero counts
    offer(32'd100, 32'd5, -32'd5);
    offer(32'd5000, 32'd10, -32'd10);                   // exactly one period
    offer(32'd9999, 32'd20, 32'd20);                    // one microsecond short
    offer(32'd10000, 32'h7FFF_FFF0, -32'd3);            // left clips high
    offer(32'd15000, 32'h8000_0010, 32'h8000_0000);     // left count wraps, right clips low
    offer(32'd20000, 32'h8000_0010, 32'h7FFF_FFFF);     // left still, right one step back
    offer(32'hFFFF_FF00, 32'h8000_0011, 32'h7FFF_FFFE); // very long gap
    offer(32'h0000_1000, 32'h8000_0100, 32'h7FFF_FF10); // across time wrap, too early
    offer(32'h0000_1288, 32'h8000_0111, 32'h7FFF_FF00); // across time wrap, exact period
    offer(32'h0000_1287, 32'h8000_0112, 32'h7FFF_FEFF); // largest elapsed time

    // zero period behaves as one microsecond, full-scale resolution
    reconfigure(24'd0, 24'hFF_FFFF);
    offer(32'h0000_1287, prev_l + 32'd7, prev_r);       // no time elapsed
    offer(32'h0000_1288, prev_l + 32'd1000000, prev_r);
    offer(32'h0000_1289, prev_l - 32'd1, prev_r + 32'd1);
    offer(32'h0000_128B, prev_l, prev_r);

    // zero resolution: every speed is zero
    reconfigure(24'd1, 24'd0);
    offer(32'h0000_128C, prev_l + 32'h8000_0000, prev_r - 32'd12345);
    offer(32'h0000_128C, prev_l + 32'd3, prev_r);

    // upper data bits beyond the period field are dropped: longest period
    reconfigure(24'hFF_FFFF, 24'd1);
    offer(last_used + 32'd1048574, prev_l + 32'd9, prev_r);
    offer(last_used + 32'd1048575, prev_l + 32'h7FFF_FFFF, prev_r + 32'h8000_0000);

    // random part, several register settings
    reconfigure(24'(PERIOD_RST), RES_RST);
    run_phase(100);
    long_hold = 1'b1;                 // receiver backs up while samples keep coming
    run_phase(120);
    drain();                          // let every result out before carrying on
    run_phase(100);
    reconfigure(24'd1, 24'hFF_FFFF);
    run_phase(200);
    reconfigure(24'd0, 24'd1);
    run_phase(200);
    reconfigure(24'd20000, 24'd500000);
    run_phase(200);
    reconfigure(24'hFF_FFFF, RES_RST);
    run_phase(180);
    reconfigure(24'd300, 24'd0);
    run_phase(150);
    reconfigure(24'd1000, 24'd12345);
    run_phase(100);

    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin : watchdog
    #4000000;
    $display("Verification failed");
    $finish;
  end

endmodule
